/* design/are_pkg.sv */
// ----------------------------------------------------------------------------
// are_pkg
// Shared types and constants for the adaptive range encoder.
// ----------------------------------------------------------------------------
package are_pkg;

	localparam int SYMBOLS     = 256;
	localparam int SYM_W       = 8;
	localparam int ADDR_W      = 9;
	localparam int CNT_W       = 15;
	localparam int FLUSH_BYTES = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0]      TOP_VALUE    = 32'h0100_0000;
	localparam logic [31:0]      BOTTOM_VALUE = 32'h0001_0000;
	localparam logic [31:0]      INIT_RANGE   = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] LIMIT_RESET  = 15'd16384;
	localparam logic [CNT_W-1:0] TOTAL_RESET  = CNT_W'(SYMBOLS);
	localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(SYMBOLS);

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_end;
	} out_item_t;

	// queue to coder hand-off
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} handoff_t;

endpackage

/* design/are_front.sv */
// ----------------------------------------------------------------------------
// are_front
// Input side: takes words and holds them in a short queue for the coder.
// ----------------------------------------------------------------------------
module are_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  are_pkg::in_item_t item,
	output are_pkg::handoff_t hq,
	input  logic              hq_ready
);

	are_pkg::in_item_t slot_q [are_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign item_ready = (count_q != 2'(are_pkg::QUEUE_DEPTH));
	assign push       = item_valid && item_ready;
	assign pop        = hq.valid && hq_ready;
	assign hq.valid   = (count_q != 2'd0);
	assign hq.item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/are_core.sv */
// ----------------------------------------------------------------------------
// are_core
// Coder back end: frequency table, serial divider, renormalisation, flush.
// ----------------------------------------------------------------------------
module are_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  are_pkg::handoff_t          hq,
	output logic                       hq_ready,
	input  logic                       cfg_we,
	input  logic [are_pkg::CNT_W-1:0]  cfg_wdata,
	output logic                       result_valid,
	input  logic                       result_ready,
	output are_pkg::out_item_t         result
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOAD, S_DIV, S_MUL, S_APPLY,
		S_RENORM, S_UPD, S_RESC, S_FLUSH
	} state_t;

	localparam int AW = are_pkg::ADDR_W;
	localparam int CW = are_pkg::CNT_W;

	// cumulative frequency table
	logic [CW-1:0] mem [are_pkg::SYMBOLS+1];
	logic [CW-1:0] rdata0_q, rdata1_q;
	logic [AW-1:0] raddr0, raddr1, waddr;
	logic [CW-1:0] wdata;
	logic          we;

	state_t        state_q;
	logic [CW-1:0] limit_q;
	logic [CW-1:0] total_q;
	logic [31:0]   low_q, range_q;
	logic [7:0]    sym_q;
	logic          last_q;
	logic [CW-1:0] lo_q, hi_q, div_q, rem_q;
	logic [31:0]   quo_q;
	logic [4:0]    dcnt_q;
	logic [31:0]   plo_q, prng_q;
	logic [1:0]    step_q;
	logic [2:0]    fcnt_q;
	logic [AW-1:0] ptr_q, waddr_q;
	logic          ptr_done_q, pend_q;
	logic [CW-1:0] prev_q, acc_q;
	logic          res_valid_q;
	are_pkg::out_item_t res_q;

	logic          res_free, take, res_load;
	logic [CW:0]   trial;
	logic          ge;
	logic [CW:0]   trial_sub;
	logic [31:0]   plo, prng;
	logic [31:0]   sum0, rng_c, nlow, nrng, nsum, neg_low;
	logic          straddle, emit0, emit1;
	logic [CW-1:0] cnt, acc_n;
	logic [AW-1:0] sym_next;

	assign res_free     = !res_valid_q || result_ready;
	assign hq_ready     = (state_q == S_IDLE);
	assign take         = hq.valid && hq_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// a new output word is loaded this cycle
	assign res_load = res_free &&
		(((state_q == S_RENORM) && emit0) || (state_q == S_FLUSH));

	// one divider step
	assign trial     = {rem_q, quo_q[31]};
	assign ge        = (trial >= {1'b0, div_q});
	assign trial_sub = trial - {1'b0, div_q};

	assign plo  = quo_q * {17'd0, lo_q};
	assign prng = quo_q * {17'd0, hi_q - lo_q};

	// renormalisation: this step and a look at the next one
	assign sum0     = low_q + range_q;
	assign neg_low  = 32'd0 - low_q;
	assign straddle = ((low_q ^ sum0) >= are_pkg::TOP_VALUE);
	assign emit0    = !straddle || (range_q < are_pkg::BOTTOM_VALUE);
	assign rng_c    = straddle ? {16'd0, neg_low[15:0]} : range_q;
	assign nlow     = {low_q[23:0], 8'd0};
	assign nrng     = {rng_c[23:0], 8'd0};
	assign nsum     = nlow + nrng;
	assign emit1    = (step_q != 2'd3) &&
		(((nlow ^ nsum) < are_pkg::TOP_VALUE) || (nrng < are_pkg::BOTTOM_VALUE));

	// rescale: halve each count, keep it odd
	assign cnt   = rdata0_q - prev_q;
	assign acc_n = acc_q + ({1'b0, cnt[CW-1:1]} | CW'(1));

	assign sym_next = {1'b0, sym_q} + AW'(1);

	always_comb begin
		raddr0 = ptr_q;
		raddr1 = ptr_q;
		we     = 1'b0;
		waddr  = waddr_q;
		wdata  = rdata0_q + CW'(1);
		unique case (state_q)
			S_IDLE: begin
				raddr0 = {1'b0, hq.item.symbol};
				raddr1 = {1'b0, hq.item.symbol} + AW'(1);
			end
			S_UPD: begin
				we = pend_q;
			end
			S_RESC: begin
				we    = pend_q;
				wdata = acc_n;
			end
			S_CLEAR: begin
				we    = 1'b1;
				waddr = ptr_q;
				wdata = CW'(ptr_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata0_q <= mem[raddr0];
		rdata1_q <= mem[raddr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			limit_q     <= are_pkg::LIMIT_RESET;
			total_q     <= are_pkg::TOTAL_RESET;
			low_q       <= '0;
			range_q     <= are_pkg::INIT_RANGE;
			ptr_q       <= '0;
			ptr_done_q  <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (res_load) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == are_pkg::LAST_ADDR) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (take) begin
						sym_q   <= hq.item.symbol;
						last_q  <= hq.item.is_last;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					lo_q    <= rdata0_q;
					hi_q    <= rdata1_q;
					div_q   <= (total_q == '0) ? CW'(1) : total_q;
					rem_q   <= '0;
					quo_q   <= range_q;
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
					quo_q  <= {quo_q[30:0], ge};
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) state_q <= S_MUL;
				end
				S_MUL: begin
					plo_q   <= plo;
					prng_q  <= prng;
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					low_q   <= low_q + plo_q;
					range_q <= prng_q;
					step_q  <= '0;
					state_q <= S_RENORM;
				end
				S_RENORM: begin
					if (!emit0 || (res_free && !emit1)) begin
						ptr_q      <= sym_next;
						ptr_done_q <= 1'b0;
						pend_q     <= 1'b0;
						total_q    <= total_q + CW'(1);
						state_q    <= S_UPD;
					end
					if (emit0 && res_free) begin
						res_q.out_byte    <= low_q[31:24];
						res_q.run_last    <= !last_q && !emit1;
						res_q.stream_end  <= 1'b0;
						low_q             <= nlow;
						range_q           <= nrng;
						step_q            <= step_q + 2'd1;
					end
				end
				S_UPD, S_RESC: begin
					if (state_q == S_RESC && pend_q) begin
						prev_q <= rdata0_q;
						acc_q  <= acc_n;
					end
					if (!ptr_done_q) begin
						ptr_q      <= ptr_q + AW'(1);
						ptr_done_q <= (ptr_q == are_pkg::LAST_ADDR);
						pend_q     <= 1'b1;
						waddr_q    <= ptr_q;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							priority if (state_q == S_RESC) begin
								total_q <= acc_q;
								state_q <= S_IDLE;
							end else if (last_q) begin
								fcnt_q  <= '0;
								state_q <= S_FLUSH;
							end else if (total_q >= limit_q) begin
								ptr_q      <= AW'(1);
								ptr_done_q <= 1'b0;
								prev_q     <= '0;
								acc_q      <= '0;
								state_q    <= S_RESC;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_FLUSH: begin
					if (res_free) begin
						res_q.out_byte   <= low_q[31:24];
						res_q.run_last   <= (fcnt_q == 3'(are_pkg::FLUSH_BYTES - 1));
						res_q.stream_end <= (fcnt_q == 3'(are_pkg::FLUSH_BYTES - 1));
						fcnt_q           <= fcnt_q + 3'd1;
						if (fcnt_q == 3'(are_pkg::FLUSH_BYTES - 1)) begin
							low_q   <= '0;
							range_q <= are_pkg::INIT_RANGE;
							total_q <= are_pkg::TOTAL_RESET;
							ptr_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							low_q <= nlow;
						end
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !hq_ready)
		else $error("coder took a word while clearing the table");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.stream_end) |-> res_q.run_last)
		else $error("stream end without run end");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_q != '0))
		else $error("zero divisor in divider");

	a_clear_resets_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (total_q == are_pkg::TOTAL_RESET))
		else $error("total not at reset value during clear");
`endif

endmodule

/* design/adaptive_range_encoder_top.sv */
// ----------------------------------------------------------------------------
// adaptive_range_encoder_top
// Order-0 adaptive range encoder: one byte symbol in, coded bytes out.
// ----------------------------------------------------------------------------
// each input word carries one symbol and an end-of-stream mark; the coder
// divides its 32-bit range by the frequency total one quotient bit a cycle,
// then multiplies, renormalises (up to four bytes, one a cycle while the
// output register is free) and walks the 257-entry table memory once to add
// one to every entry above the symbol, one entry a cycle; when the total
// reaches the limit on a word that is not the last, the counts are also
// halved in a second walk. a last word also gives five flush bytes and is
// followed by a table clearing pass; the same pass runs after reset. input
// words keep queueing (two deep) while the coder works
// ----------------------------------------------------------------------------
module adaptive_range_encoder_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  are_pkg::in_item_t         item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output are_pkg::out_item_t        result,
	input  logic                      cfg_we,
	input  logic [are_pkg::CNT_W-1:0] cfg_wdata
);

	are_pkg::handoff_t hq;
	logic              hq_ready;

	// input queue
	are_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.hq         (hq),
		.hq_ready   (hq_ready)
	);

	// coder, model and output word register
	are_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.hq           (hq),
		.hq_ready     (hq_ready),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* dv/adaptive_range_encoder_top_tb.sv */
// ----------------------------------------------------------------------------
// adaptive_range_encoder_top_tb
// Self-checking bench for the order-0 adaptive range encoder: symbols are
// sent as words, the expected coded bytes are worked out alongside and every
// output word is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module adaptive_range_encoder_top_tb;

	localparam int CYCLE_LIMIT  = 2000000;
	// worst silent run: three queued words, each with division, table walk
	// and halving pass
	localparam int SETTLE_CYCLES = 2500;
	localparam int MAX_SHOWN    = 10;

	logic                          clk;
	logic                          arst_n;
	logic                          item_valid;
	logic                          item_ready;
	are_pkg::in_item_t             item;
	logic                          result_valid;
	logic                          result_ready;
	are_pkg::out_item_t            result;
	logic                          cfg_we;
	logic [are_pkg::CNT_W-1:0]     cfg_wdata;

	adaptive_range_encoder_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	// clock: period 4
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// encoder model state, own copy
	// ------------------------------------------------------------------
	logic [are_pkg::CNT_W-1:0] freq_cum [0:are_pkg::SYMBOLS];
	logic [31:0]               enc_low;
	logic [31:0]               enc_range;
	logic [are_pkg::CNT_W-1:0] halve_limit;

	are_pkg::out_item_t coded_bytes [$];
	int        mismatches;
	int        hold_cycles;   // long receiver hold-off request
	int        burst_left;

	task automatic clear_model();
		for (int i = 0; i <= are_pkg::SYMBOLS; i++)
			freq_cum[i] = are_pkg::CNT_W'(i);
		enc_low   = 32'd0;
		enc_range = are_pkg::INIT_RANGE;
	endtask

	task automatic queue_coded(logic [7:0] b);
		are_pkg::out_item_t o;
		o.out_byte   = b;
		o.run_last   = 1'b0;
		o.stream_end = 1'b0;
		coded_bytes = {coded_bytes, o};
	endtask

	// codes one symbol and queues the bytes it shifts out
	task automatic encode_symbol(are_pkg::in_item_t w);
		logic [31:0]               total, step, lo, hi;
		logic [are_pkg::CNT_W-1:0] acc, cnt;
		int                        first;
		int                        sym;
		sym   = (w.symbol >= are_pkg::SYMBOLS) ? are_pkg::SYMBOLS - 1 : int'(w.symbol);
		first = coded_bytes.size();
		total = 32'(freq_cum[are_pkg::SYMBOLS]);
		if (total == 0)
			total = 1;
		lo        = 32'(freq_cum[sym]);
		hi        = 32'(freq_cum[sym + 1]);
		step      = enc_range / total;
		enc_low   = enc_low + lo * step;
		enc_range = step * (hi - lo);
		// renormalise, at most four bytes
		for (int s = 0; s < 4; s++) begin
			if ((enc_low ^ (enc_low + enc_range)) >= are_pkg::TOP_VALUE) begin
				if (enc_range >= are_pkg::BOTTOM_VALUE)
					break;
				enc_range = (32'd0 - enc_low) & (are_pkg::BOTTOM_VALUE - 1);
			end
			queue_coded(enc_low[31:24]);
			enc_range = enc_range << 8;
			enc_low   = enc_low << 8;
		end
		// adapt the counts
		for (int i = sym + 1; i <= are_pkg::SYMBOLS; i++)
			freq_cum[i] = freq_cum[i] + 1'b1;
		if (freq_cum[are_pkg::SYMBOLS] >= halve_limit) begin
			acc = '0;
			for (int i = 0; i < are_pkg::SYMBOLS; i++) begin
				cnt         = freq_cum[i + 1] - freq_cum[i];
				freq_cum[i] = acc;
				acc         = acc + ((cnt >> 1) | 1'b1);
			end
			freq_cum[are_pkg::SYMBOLS] = acc;
		end
		if (w.is_last) begin
			for (int i = 0; i < are_pkg::FLUSH_BYTES; i++) begin
				queue_coded(enc_low[31:24]);
				enc_low = enc_low << 8;
			end
			coded_bytes[coded_bytes.size() - 1].stream_end = 1'b1;
			clear_model();
		end
		if (coded_bytes.size() > first)
			coded_bytes[coded_bytes.size() - 1].run_last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// sender: entered and left at a falling edge
	// ------------------------------------------------------------------
	task automatic send_word(logic [7:0] sym, logic last);
		are_pkg::in_item_t w;
		w.symbol   = sym;
		w.is_last  = last;
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		encode_symbol(w);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// gap between bursts, sometimes none
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	endtask

	// wait until every expected byte is out, then let any silent word finish
	task automatic drain();
		item_valid <= 1'b0;
		while (coded_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(logic [are_pkg::CNT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we      <= 1'b0;
		halve_limit = v;
	endtask

	// a stream of random length; narrow alphabets make counts grow fast
	task automatic send_stream(int len);
		int lo_sym, hi_sym;
		lo_sym = $urandom_range(0, 255);
		hi_sym = ($urandom_range(0, 1) != 0) ? lo_sym + $urandom_range(0, 3) : 255;
		if (hi_sym > 255)
			hi_sym = 255;
		if (hi_sym == 255 && $urandom_range(0, 1) != 0)
			lo_sym = 0;
		for (int i = 0; i < len; i++)
			send_word(8'($urandom_range(lo_sym, hi_sym)), i == len - 1);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		// field extremes, single-symbol streams and silent words
		send_word(8'd0, 1'b1);
		send_word(8'd255, 1'b1);
		send_word(8'hAA, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'd0, 1'b0);
		send_word(8'd255, 1'b0);
		send_word(8'd128, 1'b1);
		for (int i = 0; i < 12; i++)
			send_word(8'd7, i == 11);
		drain();
	endtask

	task automatic test_limit_extremes();
		logic [are_pkg::CNT_W-1:0] limits [6];
		limits = '{15'd512, 15'd0, 15'd1, 15'd257, 15'h7FFF, 15'd16384};
		foreach (limits[k]) begin
			write_limit(limits[k]);
			repeat (3) send_stream($urandom_range(1, 16));
			drain();
		end
	endtask

	task automatic test_limit_midstream();
		// counts grow under a high limit, then the limit drops before the end
		write_limit(15'd16384);
		for (int i = 0; i < 20; i++)
			send_word(8'd3, 1'b0);
		drain();
		write_limit(15'd300);
		for (int i = 0; i < 10; i++)
			send_word(8'($urandom_range(0, 255)), i == 9);
		drain();
	endtask

	task automatic test_backpressure();
		// receiver holds off while words keep coming
		hold_cycles = 3000;
		for (int i = 0; i < 12; i++)
			send_word(8'($urandom_range(0, 255)), 1'b1);
		drain();
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 140) begin
			int len;
			if ($urandom_range(0, 9) == 0) begin
				drain();
				write_limit(15'($urandom_range(512, 16384)));
			end
			len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
			send_stream(len);
			sent += len;
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// receiver: own stall pattern plus the long hold-off
	// ------------------------------------------------------------------
	initial begin
		int mode, left;
		result_ready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				hold_cycles--;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(16, 128);
				end
				left--;
				case (mode)
				0: result_ready <= 1'b1;
				1: result_ready <= ($urandom_range(0, 1) != 0);
				default: result_ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// checker on the rising edge
	always @(posedge clk) begin
		are_pkg::out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (coded_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected word: byte %02h run_last %b stream_end %b",
						result.out_byte, result.run_last, result.stream_end);
			end else begin
				want = coded_bytes.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: expected %02h/%b/%b got %02h/%b/%b",
							want.out_byte, want.run_last, want.stream_end,
							result.out_byte, result.run_last, result.stream_end);
				end
			end
		end
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		mismatches  = 0;
		hold_cycles = 0;
		burst_left  = 0;
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		halve_limit = are_pkg::LIMIT_RESET;
		clear_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_limit_extremes();
		test_limit_midstream();
		test_backpressure();
		test_random();

		if (mismatches == 0 && coded_bytes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* adaptive_range_encoder_top.f */
design/are_pkg.sv
design/are_front.sv
design/are_core.sv
design/adaptive_range_encoder_top.sv
dv/adaptive_range_encoder_top_tb.sv
